// ----- hw/rtl/gzhc_pkg.sv -----
// gzhc_pkg: shared types and constants of the gzip header checker.
// Item structs for both channels, verdict codes and header flag bits.
// No dependencies.
`timescale 1ns / 1ps

package gzhc_pkg;

  // Default lower bound on buffer length, in bytes
  localparam int unsigned MinLengthDef = 16;

  // gzip magic bytes and method codes
  localparam logic [7:0] Magic1      = 8'h1F;
  localparam logic [7:0] Magic2      = 8'h8B;
  localparam logic [7:0] MethStored  = 8'h00;
  localparam logic [7:0] MethDeflate = 8'h08;

  // Bytes of time, extra flags and OS after the flag byte
  localparam logic [15:0] FixedLen = 16'd6;

  // Flag byte bit positions
  localparam int unsigned FlContBit    = 1;
  localparam int unsigned FlExtraBit   = 2;
  localparam int unsigned FlNameBit    = 3;
  localparam int unsigned FlCommentBit = 4;
  localparam int unsigned FlEncryptBit = 5;

  // Trailing zero bytes that make a buffer "zero size"
  localparam logic [2:0] ZeroRunLen = 3'd4;

  // Verdict codes
  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_VALID  = 3'd1,
    ST_SHORT  = 3'd2,
    ST_MAGIC  = 3'd3,
    ST_ZERO   = 3'd4,
    ST_METHOD = 3'd5,
    ST_FLAGS  = 3'd6,
    ST_TRUNC  = 3'd7
  } status_e;

  // One input item: a buffer byte and its last marker
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result item
  typedef struct packed {
    status_e     status;
    logic        in_payload;
    logic        header_done;
    logic        stored_method;
    logic [31:0] header_length;
  } out_item_t;

endpackage

// ----- hw/rtl/gzhc_in_reg.sv -----
// gzhc_in_reg: input register stage of the gzip header checker.
// Holds one accepted byte item until the parser takes it. Uses gzhc_pkg.
`timescale 1ns / 1ps

module gzhc_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gzhc_pkg::in_item_t in_item_i,
  output logic              valid_o,
  input  logic              ready_i,
  output gzhc_pkg::in_item_t item_o
);
  import gzhc_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Stage is free when empty or when its item moves on this cycle
  assign in_ready_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

// ----- hw/rtl/gzhc_parser.sv -----
// gzhc_parser: header parse state and per-byte result logic.
// Updates the parse state once per advanced item and forms the result item.
// Uses gzhc_pkg.
`timescale 1ns / 1ps

module gzhc_parser #(
  parameter int unsigned MIN_LENGTH = gzhc_pkg::MinLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic                cfg_wr_data_i,
  input  logic                advance_i,
  input  gzhc_pkg::in_item_t  item_i,
  output gzhc_pkg::out_item_t result_o
);
  import gzhc_pkg::*;

  // Buffer length only matters up to MIN_LENGTH, so the counter saturates there
  localparam int unsigned CntW   = $clog2(MIN_LENGTH + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MIN_LENGTH);

  typedef enum logic [3:0] {
    PH_MAGIC1, PH_MAGIC2, PH_METHOD, PH_FLAGS, PH_FIXED, PH_XLO, PH_XHI,
    PH_EXTRA, PH_NAME, PH_COMMENT, PH_PAYLOAD, PH_HALT
  } phase_e;

  logic            reject_q;
  phase_e          phase_q, phase_d;
  logic [CntW-1:0] byte_cnt_q, byte_cnt_d;
  logic [15:0]     skip_q, skip_d;
  logic [7:0]      flags_q, flags_d;
  status_e         err_q, err_d;
  logic [2:0]      zrun_q, zrun_d;
  logic [31:0]     hdr_cnt_q, hdr_cnt_d;
  logic            stored_q, stored_d;
  status_e         status;
  logic [7:0]      b;

  // Next phase once the extra field (or its absence) is done
  function automatic phase_e after_extra(input logic [7:0] fl);
    phase_e ph;
    if (fl[FlNameBit]) ph = PH_NAME;
    else if (fl[FlCommentBit]) ph = PH_COMMENT;
    else ph = PH_PAYLOAD;
    return ph;
  endfunction

  function automatic phase_e after_fixed(input logic [7:0] fl);
    phase_e ph;
    if (fl[FlExtraBit]) ph = PH_XLO;
    else ph = after_extra(fl);
    return ph;
  endfunction

  assign b = item_i.data_byte;

  // Next state and verdict for the item in the input register
  always_comb begin
    phase_d   = phase_q;
    skip_d    = skip_q;
    flags_d   = flags_q;
    err_d     = err_q;
    stored_d  = stored_q;
    byte_cnt_d = (byte_cnt_q == CntMax) ? byte_cnt_q : byte_cnt_q + 1'b1;
    // run of trailing zero bytes, capped at the window size
    if (b != 8'h00) zrun_d = '0;
    else if (zrun_q == ZeroRunLen) zrun_d = zrun_q;
    else zrun_d = zrun_q + 1'b1;
    hdr_cnt_d = hdr_cnt_q;
    if (phase_q != PH_PAYLOAD && phase_q != PH_HALT && hdr_cnt_q != '1) begin
      hdr_cnt_d = hdr_cnt_q + 1'b1;
    end

    unique case (phase_q)
      PH_MAGIC1: begin
        if (b == Magic1) phase_d = PH_MAGIC2;
        else begin err_d = ST_MAGIC; phase_d = PH_HALT; end
      end
      PH_MAGIC2: begin
        if (b == Magic2) phase_d = PH_METHOD;
        else begin err_d = ST_MAGIC; phase_d = PH_HALT; end
      end
      PH_METHOD: begin
        if (b == MethStored) begin
          stored_d = 1'b1;
          phase_d  = PH_FLAGS;
        end else if (b == MethDeflate) begin
          stored_d = 1'b0;
          phase_d  = PH_FLAGS;
        end else begin
          err_d   = ST_METHOD;
          phase_d = PH_HALT;
        end
      end
      PH_FLAGS: begin
        flags_d = b;
        if (reject_q && (b[FlContBit] || b[FlEncryptBit])) begin
          err_d   = ST_FLAGS;
          phase_d = PH_HALT;
        end else begin
          skip_d  = FixedLen;
          phase_d = PH_FIXED;
        end
      end
      PH_FIXED: begin
        skip_d = skip_q - 1'b1;
        if (skip_d == '0) phase_d = after_fixed(flags_q);
      end
      PH_XLO: begin
        skip_d  = {8'h00, b};
        phase_d = PH_XHI;
      end
      PH_XHI: begin
        // XLEN arrives low byte first
        skip_d  = {b, skip_q[7:0]};
        phase_d = (skip_d == '0) ? after_extra(flags_q) : PH_EXTRA;
      end
      PH_EXTRA: begin
        skip_d = skip_q - 1'b1;
        if (skip_d == '0) phase_d = after_extra(flags_q);
      end
      PH_NAME: begin
        if (b == 8'h00) phase_d = flags_q[FlCommentBit] ? PH_COMMENT : PH_PAYLOAD;
      end
      PH_COMMENT: begin
        if (b == 8'h00) phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: ;
      default: phase_d = PH_HALT;
    endcase

    // Verdict, in priority order, on the marked last byte
    status = ST_BUSY;
    if (item_i.last_byte) begin
      if (byte_cnt_d < CntMax) status = ST_SHORT;
      else if (err_d == ST_MAGIC) status = ST_MAGIC;
      else if (zrun_d == ZeroRunLen) status = ST_ZERO;
      else if (err_d != ST_BUSY) status = err_d;
      else if (phase_d != PH_PAYLOAD) status = ST_TRUNC;
      else status = ST_VALID;
    end
  end

  assign result_o.status        = status;
  assign result_o.in_payload    = (phase_q == PH_PAYLOAD);
  assign result_o.header_done   = (phase_d == PH_PAYLOAD);
  assign result_o.stored_method = stored_d;
  assign result_o.header_length = hdr_cnt_d;

  // Flag-rejection register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= 1'b1;
    end else if (cfg_wr_en_i) begin
      reject_q <= cfg_wr_data_i;
    end
  end

  // Parse state; cleared after the last byte of each buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC1;
      byte_cnt_q <= '0;
      skip_q     <= '0;
      flags_q    <= '0;
      err_q      <= ST_BUSY;
      zrun_q     <= '0;
      hdr_cnt_q  <= '0;
      stored_q   <= 1'b0;
    end else if (advance_i) begin
      if (item_i.last_byte) begin
        phase_q    <= PH_MAGIC1;
        byte_cnt_q <= '0;
        skip_q     <= '0;
        flags_q    <= '0;
        err_q      <= ST_BUSY;
        zrun_q     <= '0;
        hdr_cnt_q  <= '0;
        stored_q   <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        byte_cnt_q <= byte_cnt_d;
        skip_q     <= skip_d;
        flags_q    <= flags_d;
        err_q      <= err_d;
        zrun_q     <= zrun_d;
        hdr_cnt_q  <= hdr_cnt_d;
        stored_q   <= stored_d;
      end
    end
  end

endmodule

// ----- hw/rtl/gzhc_out_reg.sv -----
// gzhc_out_reg: result register stage of the gzip header checker.
// Holds one result item until the consumer takes it. Uses gzhc_pkg.
`timescale 1ns / 1ps

module gzhc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  gzhc_pkg::out_item_t item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gzhc_pkg::out_item_t out_item_o
);
  import gzhc_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  // Free when empty or when the held result is taken this cycle
  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- hw/rtl/gzip_header_checker.sv -----
// gzip_header_checker: top level, byte-stream gzip member header checker.
// Instantiates gzhc_in_reg, gzhc_parser and gzhc_out_reg; uses gzhc_pkg.
//
//   Channel | Signals                                 | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_item_i        | input
//   out     | out_valid_o, out_ready_i, out_item_o     | output
//   cfg     | cfg_wr_en_i, cfg_wr_data_i               | input
//
// One byte item per cycle while the output is not stalled; each item gives one
// result item through the input register, parse logic and result register.
// The parse state updates once per advanced item, so the rate is one item a cycle.
// Reset clears the parse state and sets flag rejection on; no clearing pass.
// A stalled output holds the result; the input register takes one more item only
// if it is empty, and in_ready_o then stays low until out_ready_i returns.
`timescale 1ns / 1ps

module gzip_header_checker #(
  parameter int unsigned MIN_LENGTH = gzhc_pkg::MinLengthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic                cfg_wr_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  gzhc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gzhc_pkg::out_item_t out_item_o
);
  import gzhc_pkg::*;

  logic      s1_valid;
  logic      s2_ready;
  in_item_t  s1_item;
  out_item_t result;

  // Input register
  gzhc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .valid_o    (s1_valid),
    .ready_i    (s2_ready),
    .item_o     (s1_item)
  );

  // Parse state and result logic
  gzhc_parser #(
    .MIN_LENGTH (MIN_LENGTH)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .advance_i     (s1_valid && s2_ready),
    .item_i        (s1_item),
    .result_o      (result)
  );

  // Result register
  gzhc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .ready_o     (s2_ready),
    .item_i      (result),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- sim/gzhc_checker.sv -----
// gzhc_checker: watches the byte and verdict channels of gzip_header_checker,
// predicts every result item from the accepted bytes and compares field by field.
// Uses gzhc_pkg for the item structs, verdict codes and header constants.
`timescale 1ns / 1ps

module gzhc_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic                cfg_wr_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  gzhc_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  gzhc_pkg::out_item_t out_item_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  import gzhc_pkg::*;

  typedef enum logic [3:0] {
    PhMagic1,
    PhMagic2,
    PhMethod,
    PhFlags,
    PhFixed,
    PhXlenLo,
    PhXlenHi,
    PhExtra,
    PhName,
    PhComment,
    PhPayload,
    PhHalt
  } parse_phase_e;

  // Mirror of the header parser state
  logic         reject_flags;
  parse_phase_e phase;
  logic [31:0]  buf_len;
  logic [15:0]  skip_left;
  logic [7:0]   flag_byte;
  status_e      first_err;
  logic [31:0]  tail_bytes;
  logic [31:0]  hdr_len;
  logic         stored;

  out_item_t    predicted_verdicts[$];
  int unsigned  mismatches;

  task automatic clear_parse();
    phase      = PhMagic1;
    buf_len    = '0;
    skip_left  = '0;
    flag_byte  = '0;
    first_err  = ST_BUSY;
    tail_bytes = '0;
    hdr_len    = '0;
    stored     = 1'b0;
  endtask

  function automatic parse_phase_e past_extra();
    if (flag_byte[FlNameBit]) return PhName;
    if (flag_byte[FlCommentBit]) return PhComment;
    return PhPayload;
  endfunction

  task automatic halt_with(input status_e code);
    first_err = code;
    phase     = PhHalt;
  endtask

  // Advance the parser by one byte and form the result item it gives
  task automatic parse_byte(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic       was_payload;
    status_e    verdict;
    b           = it.data_byte;
    was_payload = (phase == PhPayload);
    verdict     = ST_BUSY;

    if (buf_len != '1) buf_len++;
    tail_bytes = {tail_bytes[23:0], b};
    if (phase != PhPayload && phase != PhHalt && hdr_len != '1) hdr_len++;

    case (phase)
      PhMagic1: begin
        if (b == Magic1) phase = PhMagic2;
        else halt_with(ST_MAGIC);
      end
      PhMagic2: begin
        if (b == Magic2) phase = PhMethod;
        else halt_with(ST_MAGIC);
      end
      PhMethod: begin
        if (b == MethStored) begin
          stored = 1'b1;
          phase  = PhFlags;
        end else if (b == MethDeflate) begin
          stored = 1'b0;
          phase  = PhFlags;
        end else begin
          halt_with(ST_METHOD);
        end
      end
      PhFlags: begin
        flag_byte = b;
        if (reject_flags && (b[FlContBit] || b[FlEncryptBit])) begin
          halt_with(ST_FLAGS);
        end else begin
          skip_left = FixedLen;
          phase     = PhFixed;
        end
      end
      PhFixed: begin
        skip_left--;
        if (skip_left == 0) phase = flag_byte[FlExtraBit] ? PhXlenLo : past_extra();
      end
      PhXlenLo: begin
        skip_left = {8'h00, b};
        phase     = PhXlenHi;
      end
      PhXlenHi: begin
        skip_left = {b, skip_left[7:0]};
        phase     = (skip_left == 0) ? past_extra() : PhExtra;
      end
      PhExtra: begin
        skip_left--;
        if (skip_left == 0) phase = past_extra();
      end
      PhName: begin
        if (b == 8'h00) phase = flag_byte[FlCommentBit] ? PhComment : PhPayload;
      end
      PhComment: begin
        if (b == 8'h00) phase = PhPayload;
      end
      PhPayload: ;
      default: phase = PhHalt;
    endcase

    // Verdict priority at the marked last byte
    if (it.last_byte) begin
      if (buf_len < MinLengthDef) verdict = ST_SHORT;
      else if (first_err == ST_MAGIC) verdict = ST_MAGIC;
      else if (tail_bytes == '0) verdict = ST_ZERO;
      else if (first_err != ST_BUSY) verdict = first_err;
      else if (phase != PhPayload) verdict = ST_TRUNC;
      else verdict = ST_VALID;
    end

    res.status        = verdict;
    res.in_payload    = was_payload;
    res.header_done   = (phase == PhPayload);
    res.stored_method = stored;
    res.header_length = hdr_len;

    if (it.last_byte) clear_parse();
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Track config, check results, queue predictions
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      reject_flags = 1'b1;
      clear_parse();
      predicted_verdicts.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_wr_en_i) reject_flags = cfg_wr_data_i;

      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (predicted_verdicts.size() == 0) begin
          $error("unexpected result item: status %0d", got.status);
          mismatches++;
        end else begin
          want = predicted_verdicts.pop_front();
          report_field("status", want.status, got.status);
          report_field("in_payload", want.in_payload, got.in_payload);
          report_field("header_done", want.header_done, got.header_done);
          report_field("stored_method", want.stored_method, got.stored_method);
          report_field("header_length", want.header_length, got.header_length);
        end
      end

      if (in_valid_i && in_ready_i) begin
        parse_byte(in_item_i, want);
        predicted_verdicts.push_back(want);
      end

      pending_o    <= predicted_verdicts.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- sim/tb_gzip_header_checker.sv -----
// tb_gzip_header_checker: drives gzip buffers byte by byte into the header checker
// with random gaps and output stalls; gzhc_checker predicts and compares results.
// Depends on gzhc_pkg, gzip_header_checker and gzhc_checker.
`timescale 1ns / 1ps

module tb_gzip_header_checker;

  import gzhc_pkg::*;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemTarget = 600;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int unsigned pending;
  int unsigned fail_count;

  bit          idle_en;
  int unsigned sent;
  int unsigned quiet_cycles;
  logic [7:0]  gz_bytes[$];

  gzip_header_checker dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_item_i     (in_item),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_o    (out_item)
  );

  gzhc_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random output stalls, only while idle_en is set
  initial begin : ready_gen
    int unsigned hold_cnt;
    hold_cnt = 0;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_cnt > 0) hold_cnt--;
      else if (idle_en && $urandom_range(0, 7) == 0) hold_cnt = $urandom_range(1, 13);
      out_ready <= (hold_cnt == 0);
    end
  end

  // Watchdog: too long without any item moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, last_byte: is_last};
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic send_gz();
    foreach (gz_bytes[i]) send_byte(gz_bytes[i], i == gz_bytes.size() - 1);
  endtask

  // Stop the byte stream and wait for every predicted result to come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_reject(input logic v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random gzip buffer: mostly well-formed members, some noise and damage
  task automatic build_member();
    int unsigned style;
    int unsigned n;
    int unsigned xlen;
    int unsigned k;
    logic [7:0]  flg;
    gz_bytes.delete();
    style = $urandom_range(0, 19);

    // Pure noise, sometimes with a plausible first byte
    if (style < 2) begin
      n = $urandom_range(1, 30);
      repeat (n) gz_bytes.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) gz_bytes[0] = Magic1;
      return;
    end

    gz_bytes.push_back(Magic1);
    gz_bytes.push_back(Magic2);
    if (style == 2) begin
      k = $urandom_range(0, 1);
      gz_bytes[k] = gz_bytes[k] ^ (8'h01 << $urandom_range(0, 7));
    end

    if (style == 3) gz_bytes.push_back(8'($urandom_range(0, 255)));
    else gz_bytes.push_back($urandom_range(0, 1) ? MethStored : MethDeflate);

    // Continuation and encrypted bits left random in about a third of members
    flg = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 2) != 0) begin
      flg[FlContBit]    = 1'b0;
      flg[FlEncryptBit] = 1'b0;
    end
    gz_bytes.push_back(flg);
    repeat (FixedLen) gz_bytes.push_back(8'($urandom_range(0, 255)));

    if (flg[FlExtraBit]) begin
      xlen = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 400) : $urandom_range(0, 6);
      gz_bytes.push_back(xlen[7:0]);
      gz_bytes.push_back(xlen[15:8]);
      repeat (xlen) gz_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (flg[FlNameBit]) begin
      repeat ($urandom_range(0, 5)) gz_bytes.push_back(8'($urandom_range(1, 255)));
      gz_bytes.push_back(8'h00);
    end
    if (flg[FlCommentBit]) begin
      repeat ($urandom_range(0, 5)) gz_bytes.push_back(8'($urandom_range(1, 255)));
      gz_bytes.push_back(8'h00);
    end

    repeat ($urandom_range(0, 12)) gz_bytes.push_back(8'($urandom_range(0, 255)));
    // Trailing zero size field
    if ($urandom_range(0, 5) == 0) repeat (4) gz_bytes.push_back(8'h00);

    // Cut short anywhere, header included
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, gz_bytes.size());
      while (gz_bytes.size() > n) void'(gz_bytes.pop_back());
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    idle_en      = 1'b1;
    sent         = 0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reject(1'b1);

    // Directed: a one-byte buffer, then a minimal valid deflate member
    gz_bytes.delete();
    gz_bytes.push_back(Magic1);
    send_gz();
    gz_bytes.delete();
    gz_bytes.push_back(Magic1);
    gz_bytes.push_back(Magic2);
    gz_bytes.push_back(MethDeflate);
    gz_bytes.push_back(8'h00);
    repeat (FixedLen) gz_bytes.push_back(8'h00);
    repeat (8) gz_bytes.push_back(8'hA5);
    send_gz();

    // Random phases with flag rejection on, off, on, off; no idling in the last
    for (ph = 0; ph < 4; ph++) begin
      set_reject(ph[0] == 1'b0);
      idle_en = (ph != 3);
      while (sent < (ph + 1) * (ItemTarget / 4) + 19) begin
        build_member();
        send_gz();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/gzhc_pkg.sv
hw/rtl/gzhc_in_reg.sv
hw/rtl/gzhc_parser.sv
hw/rtl/gzhc_out_reg.sv
hw/rtl/gzip_header_checker.sv
sim/gzhc_checker.sv
sim/tb_gzip_header_checker.sv
